// File: design/lbe_pkg.sv
package lbe_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned PROD_W        = 2 * DATA_W;
  localparam int unsigned CFG_W         = 31;
  localparam int unsigned LBE_FRAC_BITS = 28;
  localparam int unsigned NUM_DIRS      = 19;
  localparam int unsigned DIR_W         = $clog2(NUM_DIRS);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic        [DATA_W-1:0] mag_t;
  typedef logic        [PROD_W-1:0] prod_t;
  typedef logic        [CFG_W-1:0]  coeff_t;
  typedef logic        [DIR_W-1:0]  dir_t;

  localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam dir_t DIR_CENTER = dir_t'(NUM_DIRS / 2);
  localparam dir_t DIR_LAST   = dir_t'(NUM_DIRS - 1);

  typedef enum logic [2:0] {
    REG_LINEAR   = 3'd0,
    REG_QUAD     = 3'd1,
    REG_NORM     = 3'd2,
    REG_W_CENTER = 3'd3,
    REG_W_AXIS   = 3'd4,
    REG_W_DIAG   = 3'd5
  } cfg_idx_e;

  localparam coeff_t RST_LINEAR   = coeff_t'(805306368);
  localparam coeff_t RST_QUAD     = coeff_t'(1207959552);
  localparam coeff_t RST_NORM     = coeff_t'(402653184);
  localparam coeff_t RST_W_CENTER = coeff_t'(89478485);
  localparam coeff_t RST_W_AXIS   = coeff_t'(14913081);
  localparam coeff_t RST_W_DIAG   = coeff_t'(7456540);

  typedef struct packed {
    coeff_t lin;
    coeff_t quad;
    coeff_t norm;
    coeff_t w_center;
    coeff_t w_axis;
    coeff_t w_diag;
  } cfg_t;

  typedef struct packed {
    data_t x;
    data_t y;
    data_t z;
  } vec_t;

  typedef struct packed {
    vec_t  u;
    data_t vnf;
    data_t wrc;
    data_t wra;
    data_t wrd;
  } cell_t;

  typedef enum logic [1:0] {
    COEF_ZERO = 2'd0,
    COEF_POS  = 2'd1,
    COEF_NEG  = 2'd2
  } coef_e;

  typedef enum logic [1:0] {
    W_CENTER = 2'd0,
    W_AXIS   = 2'd1,
    W_DIAG   = 2'd2
  } wsel_e;

  typedef struct packed {
    coef_e cx;
    coef_e cy;
    coef_e cz;
    wsel_e wsel;
  } dir_info_t;

  function automatic data_t sat_add(data_t a, data_t b);
    logic signed [DATA_W:0] t;
    t = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (t[DATA_W] != t[DATA_W-1]) begin
      return t[DATA_W] ? DATA_MIN : DATA_MAX;
    end
    return t[DATA_W-1:0];
  endfunction

  function automatic data_t sat_sub(data_t a, data_t b);
    logic signed [DATA_W:0] t;
    t = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (t[DATA_W] != t[DATA_W-1]) begin
      return t[DATA_W] ? DATA_MIN : DATA_MAX;
    end
    return t[DATA_W-1:0];
  endfunction

  function automatic mag_t mag(data_t a);
    return a[DATA_W-1] ? mag_t'(-a) : mag_t'(a);
  endfunction

  // round magnitude half away from zero, drop frac bits, saturate
  function automatic data_t rnd_sat(prod_t p, logic neg, int unsigned frac);
    logic [PROD_W:0] t;
    logic [PROD_W:0] q;
    t = {1'b0, p} + ((PROD_W+1)'(1) << (frac - 1));
    q = t >> frac;
    if (q > (PROD_W+1)'(DATA_MAX)) begin
      return neg ? DATA_MIN : DATA_MAX;
    end
    return neg ? -data_t'(q[DATA_W-1:0]) : data_t'(q[DATA_W-1:0]);
  endfunction

  function automatic data_t apply_coef(data_t s, data_t u, coef_e c);
    case (c)
      COEF_POS: return sat_add(s, u);
      COEF_NEG: return sat_sub(s, u);
      default:  return s;
    endcase
  endfunction

  function automatic data_t proj_sum(vec_t u, dir_info_t info);
    data_t s;
    s = '0;
    s = apply_coef(s, u.x, info.cx);
    s = apply_coef(s, u.y, info.cy);
    s = apply_coef(s, u.z, info.cz);
    return s;
  endfunction

  // pair k and 18-k share a projection; the higher index takes +s
  function automatic dir_info_t dir_info(dir_t d);
    dir_t k;
    k = (d > DIR_CENTER) ? dir_t'(DIR_LAST - d) : d;
    case (k)
      dir_t'(0): return '{COEF_ZERO, COEF_POS,  COEF_POS,  W_DIAG};
      dir_t'(1): return '{COEF_POS,  COEF_ZERO, COEF_POS,  W_DIAG};
      dir_t'(2): return '{COEF_ZERO, COEF_ZERO, COEF_POS,  W_AXIS};
      dir_t'(3): return '{COEF_NEG,  COEF_ZERO, COEF_POS,  W_DIAG};
      dir_t'(4): return '{COEF_ZERO, COEF_NEG,  COEF_POS,  W_DIAG};
      dir_t'(5): return '{COEF_POS,  COEF_POS,  COEF_ZERO, W_DIAG};
      dir_t'(6): return '{COEF_ZERO, COEF_POS,  COEF_ZERO, W_AXIS};
      dir_t'(7): return '{COEF_NEG,  COEF_POS,  COEF_ZERO, W_DIAG};
      dir_t'(8): return '{COEF_POS,  COEF_ZERO, COEF_ZERO, W_AXIS};
      default:   return '{COEF_ZERO, COEF_ZERO, COEF_ZERO, W_CENTER};
    endcase
  endfunction

endpackage

// File: design/lbe_in_if.sv
interface lbe_in_if;
  import lbe_pkg::*;

  logic   valid;
  logic   ready;
  coeff_t density;
  data_t  velocity_x;
  data_t  velocity_y;
  data_t  velocity_z;

  modport source (output valid, density, velocity_x, velocity_y, velocity_z, input ready);
  modport sink   (input valid, density, velocity_x, velocity_y, velocity_z, output ready);
endinterface

// File: design/lbe_out_if.sv
interface lbe_out_if;
  import lbe_pkg::*;

  logic  valid;
  logic  ready;
  dir_t  direction;
  data_t population;
  logic  last;

  modport source (output valid, direction, population, last, input ready);
  modport sink   (input valid, direction, population, last, output ready);
endinterface

// File: design/lattice_boltzmann_equilibrium_top.sv
// D3Q19 equilibrium populations. Each cell transaction (density, velocity)
// yields 19 result transactions, directions 0 to 18 in order with last on 18,
// one per cycle unless the output stalls, so sustained input is one cell per
// 19 results; that rate is set by the direction issuer, which feeds a single
// result channel one direction a cycle unless stalled. Results pass 5 cell
// stages, the issuer and 9 direction stages; up to five further cells are
// buffered in the cell pipeline, so input is taken while results wait. The
// unsigned Q3.28 coefficients and weights must be written through cfg_*
// only while the block is idle, unenforced by the block; results saturate.
module lattice_boltzmann_equilibrium_top #(
  parameter int unsigned FRAC_BITS = lbe_pkg::LBE_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  lbe_pkg::coeff_t       cfg_wdata_i,
  lbe_in_if.sink                in_i,
  lbe_out_if.source             out_o
);
  import lbe_pkg::*;

  cfg_t  cfg_q;
  vec_t  vel;
  logic  cell_valid;
  logic  cell_ready;
  cell_t cell_bus;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{RST_LINEAR, RST_QUAD, RST_NORM, RST_W_CENTER, RST_W_AXIS, RST_W_DIAG};
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_LINEAR:   cfg_q.lin      <= cfg_wdata_i;
        REG_QUAD:     cfg_q.quad     <= cfg_wdata_i;
        REG_NORM:     cfg_q.norm     <= cfg_wdata_i;
        REG_W_CENTER: cfg_q.w_center <= cfg_wdata_i;
        REG_W_AXIS:   cfg_q.w_axis   <= cfg_wdata_i;
        REG_W_DIAG:   cfg_q.w_diag   <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  assign vel = '{in_i.velocity_x, in_i.velocity_y, in_i.velocity_z};

  lbe_cell #(
    .FRAC_BITS(FRAC_BITS)
  ) u_cell (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .density_i   (in_i.density),
    .vel_i       (vel),
    .cell_valid_o(cell_valid),
    .cell_ready_i(cell_ready),
    .cell_o      (cell_bus)
  );

  lbe_dir #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dir (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cell_valid_i(cell_valid),
    .cell_ready_o(cell_ready),
    .cell_i      (cell_bus),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_dir_o   (out_o.direction),
    .out_pop_o   (out_o.population),
    .out_last_o  (out_o.last)
  );

endmodule

// File: design/lbe_cell.sv
module lbe_cell #(
  parameter int unsigned FRAC_BITS = lbe_pkg::LBE_FRAC_BITS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lbe_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lbe_pkg::coeff_t density_i,
  input  lbe_pkg::vec_t  vel_i,
  output logic           cell_valid_o,
  input  logic           cell_ready_i,
  output lbe_pkg::cell_t cell_o
);
  import lbe_pkg::*;

  localparam int unsigned NS = 5;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  // stage 0: raw products
  prod_t p_sq_x_q, p_sq_y_q, p_sq_z_q;
  prod_t p_wc_q, p_wa_q, p_wd_q;
  vec_t  u0_q;
  // stage 1 onwards: cell values
  cell_t c1_q, c2_q, c3_q, c4_q;
  data_t sq_x_q, sq_y_q, sq_z_q;
  data_t norm_q;
  prod_t p_vnf_q;

  always_comb begin
    en[NS-1] = !vld_q[NS-1] || cell_ready_i;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  assign in_ready_o   = en[0];
  assign cell_valid_o = vld_q[NS-1];
  assign cell_o       = c4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p_sq_x_q <= prod_t'(mag(vel_i.x)) * prod_t'(mag(vel_i.x));
      p_sq_y_q <= prod_t'(mag(vel_i.y)) * prod_t'(mag(vel_i.y));
      p_sq_z_q <= prod_t'(mag(vel_i.z)) * prod_t'(mag(vel_i.z));
      p_wc_q   <= prod_t'(cfg_i.w_center) * prod_t'(density_i);
      p_wa_q   <= prod_t'(cfg_i.w_axis) * prod_t'(density_i);
      p_wd_q   <= prod_t'(cfg_i.w_diag) * prod_t'(density_i);
      u0_q     <= vel_i;
    end
    if (en[1]) begin
      sq_x_q   <= rnd_sat(p_sq_x_q, 1'b0, FRAC_BITS);
      sq_y_q   <= rnd_sat(p_sq_y_q, 1'b0, FRAC_BITS);
      sq_z_q   <= rnd_sat(p_sq_z_q, 1'b0, FRAC_BITS);
      c1_q.u   <= u0_q;
      c1_q.vnf <= '0;
      c1_q.wrc <= rnd_sat(p_wc_q, 1'b0, FRAC_BITS);
      c1_q.wra <= rnd_sat(p_wa_q, 1'b0, FRAC_BITS);
      c1_q.wrd <= rnd_sat(p_wd_q, 1'b0, FRAC_BITS);
    end
    if (en[2]) begin
      norm_q <= sat_add(sat_add(sq_x_q, sq_y_q), sq_z_q);
      c2_q   <= c1_q;
    end
    if (en[3]) begin
      p_vnf_q <= prod_t'(cfg_i.norm) * prod_t'(mag_t'(norm_q));
      c3_q    <= c2_q;
    end
    if (en[4]) begin
      c4_q <= '{u: c3_q.u, vnf: rnd_sat(p_vnf_q, 1'b0, FRAC_BITS), wrc: c3_q.wrc,
                wra: c3_q.wra, wrd: c3_q.wrd};
    end
  end

endmodule

// File: design/lbe_dir.sv
module lbe_dir #(
  parameter int unsigned FRAC_BITS = lbe_pkg::LBE_FRAC_BITS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lbe_pkg::cfg_t  cfg_i,
  input  logic           cell_valid_i,
  output logic           cell_ready_o,
  input  lbe_pkg::cell_t cell_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lbe_pkg::dir_t  out_dir_o,
  output lbe_pkg::data_t out_pop_o,
  output logic           out_last_o
);
  import lbe_pkg::*;

  localparam int unsigned NS = 9;
  localparam data_t One = (FRAC_BITS >= DATA_W - 1) ? DATA_MAX
                                                     : data_t'(data_t'(1) << FRAC_BITS);

  typedef struct packed {
    dir_t  dir;
    data_t wr;
    data_t vnf;
    data_t lin;
  } carry_t;

  // direction issuer
  cell_t     cur_q;
  logic      have_q;
  dir_t      cnt_q;
  logic      issue;
  logic      take;
  dir_info_t info;
  data_t     s_d;
  data_t     wr_d;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;
  carry_t        cr_q [NS];

  data_t s_q;
  prod_t p_ss_q, p_lin_q;
  logic  lin_neg_q;
  data_t ss_q;
  prod_t p_bss_q;
  data_t bss_q;
  data_t base_q;
  data_t term_q;
  prod_t p_f_q;
  logic  f_neg_q;
  data_t f_q;

  always_comb begin
    en[NS-1] = !vld_q[NS-1] || out_ready_i;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  assign issue        = have_q && en[0];
  assign cell_ready_o = !have_q || (issue && cnt_q == DIR_LAST);
  assign take         = cell_valid_i && cell_ready_o;

  always_comb begin
    info = dir_info(cnt_q);
    s_d  = proj_sum(cur_q.u, info);
    case (info.wsel)
      W_AXIS:   wr_d = cur_q.wra;
      W_DIAG:   wr_d = cur_q.wrd;
      default:  wr_d = cur_q.wrc;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      cnt_q  <= '0;
      vld_q  <= '0;
    end else begin
      if (take) begin
        have_q <= 1'b1;
        cnt_q  <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + dir_t'(1);
        if (cnt_q == DIR_LAST) have_q <= 1'b0;
      end
      if (en[0]) vld_q[0] <= have_q;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) cur_q <= cell_i;
    for (int i = 1; i < NS; i++) begin
      if (en[i] && i != 2) cr_q[i] <= cr_q[i-1];
    end
    if (en[0]) begin
      s_q          <= s_d;
      cr_q[0].dir  <= cnt_q;
      cr_q[0].wr   <= wr_d;
      cr_q[0].vnf  <= cur_q.vnf;
      cr_q[0].lin  <= '0;
    end
    if (en[1]) begin
      p_ss_q    <= prod_t'(mag(s_q)) * prod_t'(mag(s_q));
      p_lin_q   <= prod_t'(cfg_i.lin) * prod_t'(mag(s_q));
      lin_neg_q <= s_q[DATA_W-1];
    end
    if (en[2]) begin
      ss_q    <= rnd_sat(p_ss_q, 1'b0, FRAC_BITS);
      cr_q[2] <= '{dir: cr_q[1].dir, wr: cr_q[1].wr, vnf: cr_q[1].vnf,
                   lin: rnd_sat(p_lin_q, lin_neg_q, FRAC_BITS)};
    end
    if (en[3]) begin
      p_bss_q <= prod_t'(cfg_i.quad) * prod_t'(mag_t'(ss_q));
    end
    if (en[4]) begin
      bss_q <= rnd_sat(p_bss_q, 1'b0, FRAC_BITS);
    end
    if (en[5]) begin
      base_q <= sat_sub(sat_add(One, bss_q), cr_q[4].vnf);
    end
    if (en[6]) begin
      term_q <= (cr_q[5].dir > DIR_CENTER) ? sat_add(base_q, cr_q[5].lin)
                                           : sat_sub(base_q, cr_q[5].lin);
    end
    if (en[7]) begin
      p_f_q   <= prod_t'(mag(cr_q[6].wr)) * prod_t'(mag(term_q));
      f_neg_q <= cr_q[6].wr[DATA_W-1] ^ term_q[DATA_W-1];
    end
    if (en[8]) begin
      f_q <= rnd_sat(p_f_q, f_neg_q, FRAC_BITS);
    end
  end

  assign out_valid_o = vld_q[NS-1];
  assign out_dir_o   = cr_q[NS-1].dir;
  assign out_pop_o   = f_q;
  assign out_last_o  = (cr_q[NS-1].dir == DIR_LAST);

endmodule

// File: design/lbe_checker.sv
module lbe_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input lbe_pkg::dir_t        out_direction_i,
  input lbe_pkg::data_t       out_population_i,
  input logic                 out_last_i
);
  import lbe_pkg::*;

  logic       in_txn;
  logic       out_txn;
  dir_t       exp_dir_q;
  logic [3:0] pending_q;

  assign in_txn  = in_valid_i && in_ready_i;
  assign out_txn = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_dir_q <= '0;
      pending_q <= '0;
    end else begin
      if (out_txn) exp_dir_q <= out_last_i ? dir_t'(0) : dir_t'(exp_dir_q + dir_t'(1));
      pending_q <= pending_q + 4'(in_txn) - 4'(out_txn && out_last_i);
    end
  end

  a_last_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_last_i == (out_direction_i == DIR_LAST)))
    else $error("last flag does not match direction");

  a_dir_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_direction_i == exp_dir_q))
    else $error("direction out of sequence");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pending_q != 4'd0))
    else $error("result without an accepted cell");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_direction_i) && $stable(out_population_i)))
    else $error("stalled result changed");

endmodule

bind lattice_boltzmann_equilibrium_top lbe_checker u_lbe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_direction_i (out_o.direction),
  .out_population_i(out_o.population),
  .out_last_i      (out_o.last)
);
